@@ rtl/sops_pkg.sv @@
package sops_pkg;
   localparam int LIMIT_W = 17;
   localparam int COUNT_W = 14;
   localparam int PRIME_W = 17;
   localparam int BSIZE_W = 17;
   localparam int CSR_AW = 2;
   localparam logic [CSR_AW-1:0] REG_BLOCK_SIZE = 2'd0;
   localparam logic [BSIZE_W-1:0] BSIZE_RESET = 17'd1024;

   typedef struct packed {
      logic [PRIME_W-1:0] third_largest_prime;
      logic [PRIME_W-1:0] second_largest_prime;
      logic [PRIME_W-1:0] largest_prime;
      logic [COUNT_W-1:0] prime_count;
   } result_type;
endpackage

@@ rtl/sops_divider.sv @@
module sops_divider (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [sops_pkg::LIMIT_W:0] dividend,
   input  logic [sops_pkg::LIMIT_W:0] divisor,
   output logic done,
   output logic [sops_pkg::LIMIT_W:0] remainder
);
   import sops_pkg::*;
   localparam int W = LIMIT_W + 1;

   logic [W-1:0] quo_ff, quo_in;
   logic [W-1:0] rem_ff, rem_in;
   logic [W-1:0] dsr_ff, dsr_in;
   logic [$clog2(W+1)-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [W:0] trial;

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {rem_ff, quo_ff[W-1]} - {1'b0, dsr_ff};
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dsr_in = divisor;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[W-2:0], 1'b0};
         if (!trial[W]) begin
            rem_in = trial[W-1:0];
         end else begin
            rem_in = {rem_ff[W-2:0], quo_ff[W-1]};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == ($clog2(W+1))'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done = done_ff;
   assign remainder = rem_ff;

`ifndef SYNTHESIS
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("divider done lasted two cycles");
   a_busy_done: assert property (@(posedge clock) disable iff (reset)
      done_in |-> busy_ff) else $error("divider done without busy");
   a_idle_after: assert property (@(posedge clock) disable iff (reset)
      (done_ff && !start) |-> !busy_ff) else $error("divider busy after done");
`endif
endmodule

@@ rtl/segmented_odd_prime_sieve_top.sv @@
// Flow for limit N, with M = (N+1)/2: clear the mark memory, find the integer square root,
// sieve the odd base primes up to the root and mark their multiples, then in each segment
// divide to find each base prime's first odd multiple and mark, and scan down for the result.
// Throughput: one transaction at a time.
// The mark memory is cleared by a pass over the used range (M entries) at the start of each run.
// Reset is synchronous and active high; block_size returns to 1024.
module segmented_odd_prime_sieve_top #(
   parameter int MARK_DEPTH = 65536,
   parameter int PRIME_TABLE_DEPTH = 128
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [23:0] req_tdata, // limit[16:0], zero fill
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [71:0] rsp_tdata, // prime_count[13:0], largest_prime, second, third, zero fill
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [sops_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);
   import sops_pkg::*;
   localparam int MA = $clog2(MARK_DEPTH);
   localparam int TA = $clog2(PRIME_TABLE_DEPTH);
   localparam int V = MA + 2;
   localparam logic [3:0] S_IDLE = 4'd0, S_CLR = 4'd1, S_SQRT = 4'd2, S_BRD = 4'd3,
      S_BCHK = 4'd4, S_BMK = 4'd5, S_SEG = 4'd6, S_TRD = 4'd7, S_DIV = 4'd8,
      S_MK = 4'd9, S_SCRD = 4'd10, S_SCAN = 4'd11, S_OUT = 4'd12, S_TWAIT = 4'd13;

   logic [BSIZE_W-1:0] bsize_ff;
   logic [3:0] st_ff;
   logic [V-1:0] n_ff, m_ff, b_ff, r_ff, s_ff, e_ff, idx_ff, j_ff, p_ff, v_ff;
   logic [TA:0] kcnt_ff, k_ff;
   logic [COUNT_W-1:0] cnt_ff;
   logic [1:0] found_ff;
   logic [PRIME_W-1:0] b0_ff, b1_ff, b2_ff;
   logic rsp_valid_ff;
   result_type res_ff;

   logic mem [MARK_DEPTH];
   logic [8:0] ptab [PRIME_TABLE_DEPTH];
   logic mem_rd_ff;
   logic [8:0] ptab_rd_ff;
   logic mem_we;
   logic mem_wd;
   logic [MA-1:0] mem_wa, mem_ra;

   logic div_start, div_done;
   logic [LIMIT_W:0] div_rem;
   logic [V-1:0] lim_in, sq;
   logic [V-1:0] first_w;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == REG_BLOCK_SIZE) ? {15'd0, bsize_ff} : 32'd0;
   assign req_tready = (st_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {7'd0, res_ff};

   assign lim_in = (V)'(req_tdata[LIMIT_W-1:0]) > (V)'(2*MARK_DEPTH-1)
      ? (V)'(2*MARK_DEPTH-1) : (V)'(req_tdata[LIMIT_W-1:0]);
   assign sq = (r_ff + 1'b1) * (r_ff + 1'b1);

   sops_divider u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend((LIMIT_W+1)'(v_ff)), .divisor((LIMIT_W+1)'(ptab_rd_ff)),
      .done(div_done), .remainder(div_rem)
   );

   always_comb begin
      logic [V-1:0] q;
      q = (V)'(div_rem);
      first_w = (q == '0) ? v_ff : v_ff + (p_ff - q);
      if (!first_w[0]) first_w = first_w + p_ff;
   end

   always_comb begin
      mem_we = 1'b0;
      mem_wd = 1'b1;
      mem_wa = j_ff[MA-1:0];
      mem_ra = idx_ff[MA-1:0];
      div_start = 1'b0;
      if (st_ff == S_CLR) begin
         mem_we = 1'b1;
         mem_wd = 1'b0;
         mem_wa = idx_ff[MA-1:0];
      end else if ((st_ff == S_BMK && j_ff < b_ff) || (st_ff == S_MK && j_ff < e_ff)) begin
         mem_we = 1'b1;
      end
      if (st_ff == S_TWAIT) div_start = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      mem_rd_ff <= mem[mem_ra];
      ptab_rd_ff <= ptab[k_ff[TA-1:0]];
      if (st_ff == S_BCHK && !mem_rd_ff && kcnt_ff < (TA+1)'(PRIME_TABLE_DEPTH))
         ptab[kcnt_ff[TA-1:0]] <= 9'(2 * idx_ff + 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         bsize_ff <= BSIZE_RESET;
         rsp_valid_ff <= 1'b0;
         kcnt_ff <= '0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_paddr == REG_BLOCK_SIZE)
            bsize_ff <= csr_pwdata[BSIZE_W-1:0];
         if (st_ff == S_OUT && (!rsp_valid_ff || rsp_tready)) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
         case (st_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  n_ff <= lim_in;
                  m_ff <= (lim_in + 1'b1) >> 1;
                  idx_ff <= '0;
                  r_ff <= '0;
                  st_ff <= (lim_in < (V)'(2)) ? S_OUT : S_CLR;
               end
            end
            S_CLR: begin
               idx_ff <= idx_ff + 1'b1;
               if (idx_ff + 1'b1 >= m_ff) st_ff <= S_SQRT;
            end
            S_SQRT: begin
               if (sq <= n_ff) r_ff <= r_ff + 1'b1;
               else begin
                  b_ff <= (r_ff + 1'b1) >> 1;
                  idx_ff <= (V)'(1);
                  kcnt_ff <= '0;
                  st_ff <= S_BRD;
               end
            end
            S_BRD: begin
               if (idx_ff >= b_ff) begin
                  s_ff <= b_ff;
                  st_ff <= S_SEG;
               end else st_ff <= S_BCHK;
            end
            S_BCHK: begin
               if (mem_rd_ff) begin
                  idx_ff <= idx_ff + 1'b1;
                  st_ff <= S_BRD;
               end else begin
                  if (kcnt_ff < (TA+1)'(PRIME_TABLE_DEPTH)) kcnt_ff <= kcnt_ff + 1'b1;
                  p_ff <= (V)'(2 * idx_ff + 1'b1);
                  j_ff <= (V)'(((2 * idx_ff + 1'b1) * (2 * idx_ff + 1'b1) - 1'b1) >> 1);
                  st_ff <= S_BMK;
               end
            end
            S_BMK: begin
               if (j_ff < b_ff) j_ff <= j_ff + p_ff;
               else begin
                  idx_ff <= idx_ff + 1'b1;
                  st_ff <= S_BRD;
               end
            end
            S_SEG: begin
               if (s_ff >= m_ff) begin
                  idx_ff <= m_ff - 1'b1;
                  cnt_ff <= (COUNT_W)'(1);
                  found_ff <= '0;
                  b0_ff <= '0; b1_ff <= '0; b2_ff <= '0;
                  st_ff <= S_SCRD;
               end else begin
                  if ((V)'(bsize_ff == '0 ? 1 : bsize_ff) > m_ff - s_ff) e_ff <= m_ff;
                  else e_ff <= s_ff + (V)'(bsize_ff == '0 ? 1 : bsize_ff);
                  v_ff <= (V)'(2 * s_ff + 1'b1);
                  k_ff <= '0;
                  st_ff <= S_TRD;
               end
            end
            S_TRD: begin
               if (k_ff >= kcnt_ff) begin
                  s_ff <= e_ff;
                  st_ff <= S_SEG;
               end else st_ff <= S_TWAIT;
            end
            S_TWAIT: begin
               p_ff <= (V)'(ptab_rd_ff);
               st_ff <= S_DIV;
            end
            S_DIV: begin
               if (div_done) begin
                  j_ff <= (first_w - 1'b1) >> 1;
                  st_ff <= S_MK;
               end
            end
            S_MK: begin
               if (j_ff < e_ff) j_ff <= j_ff + p_ff;
               else begin
                  k_ff <= k_ff + 1'b1;
                  st_ff <= S_TRD;
               end
            end
            S_SCRD: begin
               if (idx_ff == '0) begin
                  if (found_ff == 2'd0) b0_ff <= (PRIME_W)'(2);
                  else if (found_ff == 2'd1) b1_ff <= (PRIME_W)'(2);
                  else if (found_ff == 2'd2) b2_ff <= (PRIME_W)'(2);
                  st_ff <= S_OUT;
               end else st_ff <= S_SCAN;
            end
            S_SCAN: begin
               if (!mem_rd_ff) begin
                  cnt_ff <= cnt_ff + 1'b1;
                  if (found_ff == 2'd0) b0_ff <= (PRIME_W)'(2 * idx_ff + 1'b1);
                  else if (found_ff == 2'd1) b1_ff <= (PRIME_W)'(2 * idx_ff + 1'b1);
                  else if (found_ff == 2'd2) b2_ff <= (PRIME_W)'(2 * idx_ff + 1'b1);
                  if (found_ff != 2'd3) found_ff <= found_ff + 1'b1;
               end
               idx_ff <= idx_ff - 1'b1;
               st_ff <= S_SCRD;
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  if (n_ff < (V)'(2)) res_ff <= '0;
                  else res_ff <= '{third_largest_prime: b2_ff, second_largest_prime: b1_ff,
                                  largest_prime: b0_ff, prime_count: cnt_ff};
                  st_ff <= S_IDLE;
               end
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid) else $error("result dropped");
   a_idle_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> st_ff != S_IDLE) else $error("transaction lost");
   a_found_range: assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_SCAN) |-> idx_ff < m_ff) else $error("scan out of range");
`endif
endmodule
